// ===== design/local_maximum_3x3_detector_core_macros.svh =====
// Assertion macros for the 3x3 local maximum detector.
// Used by the port checker; no other dependencies.
`ifndef LOCAL_MAXIMUM_3X3_DETECTOR_CORE_MACROS_SVH
`define LOCAL_MAXIMUM_3X3_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LMD3_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmd3 port check failed");

// Next-cycle implication, disabled during reset.
`define LMD3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmd3 port check failed");

`endif

// ===== design/lmd3_pkg.sv =====
// Shared constants and types for the 3x3 local maximum detector.
// No dependencies; imported by the core and its port checker.
`default_nettype none

package lmd3_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_PIXEL_BITS = 16;
    localparam int DEFAULT_DIM    = 1024;

    localparam int COLUMN_BITS    = 10;
    localparam int ROW_BITS       = 10;
    localparam int VALUE_BITS     = 16;
    localparam int CFG_DATA_BITS  = 11;
    localparam int CFG_INDEX_BITS = 2;

    localparam int FIFO_DEPTH     = 4;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = CFG_INDEX_BITS'(1);

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic [COLUMN_BITS-1:0] column;
        logic [ROW_BITS-1:0]    row;
        logic [VALUE_BITS-1:0]  value;
        logic                   is_peak;
        logic                   frame_done;
    } result_t;

    typedef struct packed {
        result_t first;
        result_t second;
        logic    two;
    } entry_t;

endpackage

`default_nettype wire

// ===== design/local_maximum_3x3_detector_core.sv =====
// 3x3 local maximum detector core; uses lmd3_pkg.
// A result passes through the stage-1 registers and then the result queue.
// Throughput: one request per cycle while in_stall is low; a last-column request yields
// up to two results, which drain from a 4-entry result queue at one result per cycle while out_stall is low.
// Reset clears counters, pipeline and queue and sets each dimension to the smaller of 1024 and its maximum;
// the line memory is not cleared.
`default_nettype none

module local_maximum_3x3_detector_core #(
    parameter int MAX_WIDTH  = lmd3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lmd3_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = lmd3_pkg::DEF_PIXEL_BITS
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  wire                                  operation,
    input  wire  [PIXEL_BITS-1:0]                pixel_value,
    input  wire                                  cfg_write_en,
    input  wire  [lmd3_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire  [lmd3_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output logic                                 out_valid,
    input  wire                                  out_stall,
    output logic [lmd3_pkg::COLUMN_BITS-1:0]     column,
    output logic [lmd3_pkg::ROW_BITS-1:0]        row,
    output logic [lmd3_pkg::VALUE_BITS-1:0]      value,
    output logic                                 is_peak,
    output logic                                 frame_done,
    output logic                                 last_of_item
);
    import lmd3_pkg::*;

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int RW   = $clog2(MAX_HEIGHT + 1);
    localparam int LW   = WW + 1;
    localparam int CX_W = (AW > COLUMN_BITS) ? AW : COLUMN_BITS;
    localparam int RX_W = (RW > ROW_BITS) ? RW : ROW_BITS;
    localparam int PX_W = (PIXEL_BITS > VALUE_BITS) ? PIXEL_BITS : VALUE_BITS;
    localparam int FP   = $clog2(FIFO_DEPTH);
    localparam int CNTW = $clog2(FIFO_DEPTH + 1);

    localparam logic [WW-1:0] FW_RESET =
        WW'((MAX_WIDTH < DEFAULT_DIM) ? MAX_WIDTH : DEFAULT_DIM);
    localparam logic [RW-1:0] FH_RESET =
        RW'((MAX_HEIGHT < DEFAULT_DIM) ? MAX_HEIGHT : DEFAULT_DIM);

    // frame geometry and stream position
    logic [WW-1:0] frame_width_reg;
    logic [RW-1:0] frame_height_reg;
    logic [AW-1:0] col_cnt_reg;
    logic [RW-1:0] row_cnt_reg;
    logic [WW-1:0] fw_clamped;
    logic [RW-1:0] fh_clamped;
    logic          cfg_hit;

    logic          in_fire;
    logic          take;
    logic          flushing0;
    logic [LW-1:0] col_plus;
    logic          last0;

    // stage 1
    logic                  s1_valid_reg;
    logic [AW-1:0]         s1_x_reg;
    logic [RW-1:0]         s1_y_reg;
    logic                  s1_flush_reg;
    logic                  s1_last_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;

    // line memory: {upper, middle} per column
    logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
    logic [2*PIXEL_BITS-1:0] rd_data_reg;
    logic [2*PIXEL_BITS-1:0] fwd_data_reg;
    logic                    fwd_hit_reg;
    logic [2*PIXEL_BITS-1:0] pair;
    logic [PIXEL_BITS-1:0]   up_rd;
    logic [PIXEL_BITS-1:0]   mid_rd;
    logic                    mem_we;
    logic [2*PIXEL_BITS-1:0] mem_wdata;

    // window [column][row]
    logic [PIXEL_BITS-1:0] win_reg [3][3];
    logic [PIXEL_BITS-1:0] nc  [3];
    logic [PIXEL_BITS-1:0] nw0 [3];
    logic [PIXEL_BITS-1:0] nw1 [3];
    logic [PIXEL_BITS-1:0] nw2 [3];
    logic [2:0]            rowok;
    logic                  colok0;
    logic                  colok1;
    logic                  peak_a;
    logic                  peak_b;
    logic                  v_a;
    logic                  v_b;

    logic [CX_W-1:0] col_a_ext;
    logic [CX_W-1:0] col_b_ext;
    logic [RX_W-1:0] row_ext;
    logic [PX_W-1:0] val_a_ext;
    logic [PX_W-1:0] val_b_ext;
    result_t         res_a;
    result_t         res_b;
    entry_t          push_entry;
    logic            push;

    // result queue
    entry_t            fifo_mem [FIFO_DEPTH];
    logic [FP-1:0]     wr_ptr_reg;
    logic [FP-1:0]     rd_ptr_reg;
    logic [CNTW-1:0]   fifo_cnt_reg;
    logic              phase_reg;
    entry_t            head;
    result_t           cur;
    logic              pop_res;
    logic              pop_entry;
    logic [CNTW:0]     occupancy;

    // configuration
    always_comb
    begin
        if (cfg_data == '0)
            fw_clamped = WW'(1);
        else if (32'(cfg_data) > 32'(MAX_WIDTH))
            fw_clamped = WW'(MAX_WIDTH);
        else
            fw_clamped = WW'(cfg_data);

        if (cfg_data == '0)
            fh_clamped = RW'(1);
        else if (32'(cfg_data) > 32'(MAX_HEIGHT))
            fh_clamped = RW'(MAX_HEIGHT);
        else
            fh_clamped = RW'(cfg_data);
    end

    assign cfg_hit = cfg_write_en &&
                     (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT);

    // stage 0: accept and address the line memory
    assign occupancy = (CNTW+1)'(fifo_cnt_reg) + (CNTW+1)'(s1_valid_reg) + (CNTW+1)'(1);
    assign in_stall  = occupancy > (CNTW+1)'(FIFO_DEPTH);
    assign in_fire   = in_valid && !in_stall;
    assign flushing0 = row_cnt_reg >= frame_height_reg;
    assign take      = in_fire && (flushing0 || operation == OP_PIXEL);
    assign col_plus  = LW'(col_cnt_reg) + LW'(1);
    assign last0     = col_plus >= LW'(frame_width_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FW_RESET;
            frame_height_reg <= FH_RESET;
            col_cnt_reg      <= '0;
            row_cnt_reg      <= '0;
        end
        else if (cfg_hit)
        begin
            if (cfg_index == CFG_FRAME_WIDTH)
                frame_width_reg <= fw_clamped;
            else
                frame_height_reg <= fh_clamped;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (take)
        begin
            if (last0)
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= flushing0 ? '0 : row_cnt_reg + RW'(1);
            end
            else
            begin
                col_cnt_reg <= col_plus[AW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= take;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_x_reg     <= col_cnt_reg;
            s1_y_reg     <= row_cnt_reg;
            s1_flush_reg <= flushing0;
            s1_last_reg  <= last0;
            s1_pix_reg   <= pixel_value;
        end
    end

    // line memory with write-to-read forwarding
    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[s1_x_reg] <= mem_wdata;
        rd_data_reg  <= line_mem[col_cnt_reg];
        fwd_hit_reg  <= mem_we && (s1_x_reg == col_cnt_reg);
        fwd_data_reg <= mem_wdata;
    end

    // stage 1: shift window, write back, judge
    assign pair      = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign up_rd     = pair[2*PIXEL_BITS-1:PIXEL_BITS];
    assign mid_rd    = pair[PIXEL_BITS-1:0];
    assign mem_we    = s1_valid_reg && !s1_flush_reg;
    assign mem_wdata = {mid_rd, s1_pix_reg};

    always_comb
    begin
        nc[0] = up_rd;
        nc[1] = mid_rd;
        nc[2] = s1_flush_reg ? '0 : s1_pix_reg;
        for (int r = 0; r < 3; r++)
        begin
            nw0[r] = win_reg[1][r];
            nw1[r] = win_reg[2][r];
            nw2[r] = nc[r];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= nc;
        end
    end

    assign rowok[0] = (s1_y_reg >> 1) != '0;
    assign rowok[1] = s1_y_reg != '0;
    assign rowok[2] = !s1_flush_reg;
    assign colok0   = (s1_x_reg >> 1) != '0;
    assign colok1   = s1_x_reg != '0;

    always_comb
    begin
        peak_a = 1'b1;
        peak_b = 1'b1;
        for (int r = 0; r < 3; r++)
        begin
            if (rowok[r])
            begin
                if (colok0 && nw0[r] > nw1[1])
                    peak_a = 1'b0;
                if (nw1[r] > nw1[1])
                    peak_a = 1'b0;
                if (nw2[r] > nw1[1])
                    peak_a = 1'b0;
                if (colok1 && nw1[r] > nw2[1])
                    peak_b = 1'b0;
                if (nw2[r] > nw2[1])
                    peak_b = 1'b0;
            end
        end
    end

    assign v_a       = rowok[1] && colok1;
    assign v_b       = rowok[1] && s1_last_reg;
    assign col_a_ext = CX_W'(s1_x_reg - AW'(1));
    assign col_b_ext = CX_W'(s1_x_reg);
    assign row_ext   = RX_W'(s1_y_reg - RW'(1));
    assign val_a_ext = PX_W'(nw1[1]);
    assign val_b_ext = PX_W'(nw2[1]);

    always_comb
    begin
        res_a.column     = col_a_ext[COLUMN_BITS-1:0];
        res_a.row        = row_ext[ROW_BITS-1:0];
        res_a.value      = val_a_ext[VALUE_BITS-1:0];
        res_a.is_peak    = peak_a;
        res_a.frame_done = 1'b0;

        res_b.column     = col_b_ext[COLUMN_BITS-1:0];
        res_b.row        = row_ext[ROW_BITS-1:0];
        res_b.value      = val_b_ext[VALUE_BITS-1:0];
        res_b.is_peak    = peak_b;
        res_b.frame_done = s1_flush_reg;

        push_entry.first  = v_a ? res_a : res_b;
        push_entry.second = res_b;
        push_entry.two    = v_a && v_b;
    end

    assign push = s1_valid_reg && (v_a || v_b);

    // result queue
    assign head         = fifo_mem[rd_ptr_reg];
    assign cur          = phase_reg ? head.second : head.first;
    assign out_valid    = fifo_cnt_reg != '0;
    assign last_of_item = phase_reg || !head.two;
    assign column       = cur.column;
    assign row          = cur.row;
    assign value        = cur.value;
    assign is_peak      = cur.is_peak;
    assign frame_done   = cur.frame_done;
    assign pop_res      = out_valid && !out_stall;
    assign pop_entry    = pop_res && last_of_item;

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            phase_reg    <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FP'(1);
            if (pop_entry)
                rd_ptr_reg <= rd_ptr_reg + FP'(1);
            if (push && !pop_entry)
                fifo_cnt_reg <= fifo_cnt_reg + CNTW'(1);
            else if (!push && pop_entry)
                fifo_cnt_reg <= fifo_cnt_reg - CNTW'(1);
            if (pop_res)
                phase_reg <= !last_of_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/lmd3_checker.sv =====
// Port checker for the 3x3 local maximum detector core, bound to its top level.
// Depends on lmd3_pkg and local_maximum_3x3_detector_core_macros.svh.
`default_nettype none

`include "local_maximum_3x3_detector_core_macros.svh"

module lmd3_checker (
    input wire                               clk,
    input wire                               rst_n,
    input wire                               out_valid,
    input wire                               out_stall,
    input wire [lmd3_pkg::COLUMN_BITS-1:0]   column,
    input wire [lmd3_pkg::ROW_BITS-1:0]      row,
    input wire [lmd3_pkg::VALUE_BITS-1:0]    value,
    input wire                               is_peak,
    input wire                               frame_done,
    input wire                               last_of_item
);
    import lmd3_pkg::*;

    `LMD3_ASSERT_NEXT(a_out_valid_holds, clk, rst_n, out_valid && out_stall, out_valid)
    `LMD3_ASSERT_NEXT(a_out_payload_holds, clk, rst_n, out_valid && out_stall, $stable(column) && $stable(row) && $stable(value) && $stable(is_peak) && $stable(frame_done) && $stable(last_of_item))
    `LMD3_ASSERT_SAME(a_frame_done_is_last, clk, rst_n, out_valid && frame_done, last_of_item)
    `LMD3_ASSERT_NEXT(a_pair_follows, clk, rst_n, out_valid && !out_stall && !last_of_item, out_valid && column == $past(column) + 1'b1 && row == $past(row))

endmodule

bind local_maximum_3x3_detector_core lmd3_checker u_lmd3_checker (.*);

`default_nettype wire
